/* design/sha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  // Geometry of one message block and of the digest.
  localparam int BLOCK_BITS   = 512;
  localparam int WORD_BITS    = 32;
  localparam int DIGEST_WORDS = 8;
  localparam int LEN_BITS     = 64;

  // Byte positions that steer the padding sequence, and the last round and last digest word.
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  // Bytes shifted into the block buffer during padding.
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;

  // Round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Initial chain value.
  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_ADD,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_EMIT
  } sha_state_t;

  // What the block buffer takes in this cycle.
  typedef enum logic [2:0] {
    SH_NONE,
    SH_DATA,
    SH_MARK,
    SH_ZERO,
    SH_LEN,
    SH_ROUND
  } sha_shift_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    sha_shift_t shift;
    logic       init_vars;
    logic       add_chain;
    logic       emit_word;
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic round_last;
    logic word_last;
  } sha_status_t;

endpackage

`default_nettype wire

/* design/sha_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_has_byte,
  input  wire logic        in_end,
  input  wire logic        out_ready,
  input  wire sha_status_t status,
  output sha_cmd_t         cmd,
  output logic             in_ready,
  output logic             out_valid
);

  sha_state_t state_r, state_nxt;
  // Work still owed after the current compression: padding marker,
  // zero fill, or the digest output.
  logic fin_r, fin_nxt;
  logic pad_r, pad_nxt;
  logic last_r, last_nxt;

  // State and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte && status.pos_last) begin
            state_nxt = ST_COMPRESS;
            fin_nxt   = in_end;
          end else if (in_end) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (status.pos_last) begin
          state_nxt = ST_COMPRESS;
          pad_nxt   = 1'b1;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (status.pos_len) begin
          state_nxt = ST_LEN;
        end else if (status.pos_last) begin
          state_nxt = ST_COMPRESS;
          pad_nxt   = 1'b1;
        end
      end
      ST_LEN: begin
        state_nxt = ST_COMPRESS;
        last_nxt  = 1'b1;
      end
      ST_COMPRESS: begin
        if (status.round_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (last_r) begin
          state_nxt = ST_EMIT;
          last_nxt  = 1'b0;
        end else if (fin_r) begin
          state_nxt = ST_MARK;
          fin_nxt   = 1'b0;
        end else if (pad_r) begin
          state_nxt = ST_ZERO;
          pad_nxt   = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready && status.word_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '{shift: SH_NONE, init_vars: 1'b0, add_chain: 1'b0, emit_word: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_has_byte) begin
          cmd.shift     = SH_DATA;
          cmd.init_vars = status.pos_last;
        end
      end
      ST_MARK: begin
        cmd.shift     = SH_MARK;
        cmd.init_vars = status.pos_last;
      end
      ST_ZERO: begin
        if (!status.pos_len) begin
          cmd.shift     = SH_ZERO;
          cmd.init_vars = status.pos_last;
        end
      end
      ST_LEN: begin
        cmd.shift     = SH_LEN;
        cmd.init_vars = 1'b1;
      end
      ST_COMPRESS: begin
        cmd.shift = SH_ROUND;
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_word = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/sha_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha_dp
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sha_cmd_t    cmd,
  input  wire logic [7:0]  data_byte,
  output sha_status_t      status,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_number
);

  // Block buffer: the oldest word sits in the top bits. During rounds it
  // shifts one word per round and serves as the message schedule window.
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [31:0]           var_r [8];
  logic [31:0]           var_nxt [8];
  logic [31:0]           chain_r [8];
  logic [31:0]           chain_nxt [8];
  logic [5:0]            pos_r, pos_nxt;
  logic [LEN_BITS-4:0]   bytes_r, bytes_nxt;
  logic [5:0]            round_r, round_nxt;
  logic [2:0]            word_r, word_nxt;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2;
  logic [LEN_BITS-1:0] bit_len;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Message schedule taps and the next schedule word.
  assign w0  = blk_r[BLOCK_BITS-1 -: 32];
  assign w1  = blk_r[BLOCK_BITS-1-32 -: 32];
  assign w9  = blk_r[BLOCK_BITS-1-9*32 -: 32];
  assign w14 = blk_r[BLOCK_BITS-1-14*32 -: 32];
  assign w_new = w0 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
               + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

  // One compression round.
  assign t1 = var_r[7] + (rotr(var_r[4], 6) ^ rotr(var_r[4], 11) ^ rotr(var_r[4], 25))
            + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6])) + ROUND_K[round_r] + w0;
  assign t2 = (rotr(var_r[0], 2) ^ rotr(var_r[0], 13) ^ rotr(var_r[0], 22))
            + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  // The bit length is the byte count times eight.
  assign bit_len = {bytes_r, 3'b000};

  // Block buffer, byte position and length count.
  always_comb begin
    blk_nxt   = blk_r;
    pos_nxt   = pos_r;
    bytes_nxt = bytes_r;
    unique case (cmd.shift)
      SH_NONE: begin
        blk_nxt = blk_r;
      end
      SH_DATA: begin
        blk_nxt   = {blk_r[BLOCK_BITS-9:0], data_byte};
        pos_nxt   = pos_r + 6'd1;
        bytes_nxt = bytes_r + {{(LEN_BITS-4){1'b0}}, 1'b1};
      end
      SH_MARK: begin
        blk_nxt = {blk_r[BLOCK_BITS-9:0], PAD_MARKER};
        pos_nxt = pos_r + 6'd1;
      end
      SH_ZERO: begin
        blk_nxt = {blk_r[BLOCK_BITS-9:0], PAD_ZERO};
        pos_nxt = pos_r + 6'd1;
      end
      SH_LEN: begin
        blk_nxt = {blk_r[BLOCK_BITS-LEN_BITS-1:0], bit_len};
        pos_nxt = pos_r + 6'd8;
      end
      SH_ROUND: begin
        blk_nxt = {blk_r[BLOCK_BITS-33:0], w_new};
      end
      default: begin
        blk_nxt = blk_r;
      end
    endcase
    if (cmd.emit_word && (word_r == WORD_LAST)) begin
      bytes_nxt = '0;
      pos_nxt   = '0;
    end
  end

  // Working variables and round counter.
  always_comb begin
    var_nxt   = var_r;
    round_nxt = round_r;
    if (cmd.init_vars) begin
      var_nxt   = chain_r;
      round_nxt = '0;
    end else if (cmd.shift == SH_ROUND) begin
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
      round_nxt  = round_r + 6'd1;
    end
  end

  // Chain value: feed-forward add after a block, and word-by-word output
  // that refills the initial value behind the departing words.
  always_comb begin
    chain_nxt = chain_r;
    word_nxt  = word_r;
    if (cmd.add_chain) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_nxt[i] = chain_r[i] + var_r[i];
      end
    end else if (cmd.emit_word) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        chain_nxt[i] = chain_r[i+1];
      end
      chain_nxt[DIGEST_WORDS-1] = INIT_CHAIN[word_r];
      word_nxt = word_r + 3'd1;
    end
  end

  // Registers with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= INIT_CHAIN;
      pos_r   <= '0;
      bytes_r <= '0;
      round_r <= '0;
      word_r  <= '0;
    end else begin
      chain_r <= chain_nxt;
      pos_r   <= pos_nxt;
      bytes_r <= bytes_nxt;
      round_r <= round_nxt;
      word_r  <= word_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    var_r <= var_nxt;
  end

  assign status.pos_last   = (pos_r == POS_LAST);
  assign status.pos_len    = (pos_r == POS_LEN);
  assign status.round_last = (round_r == ROUND_LAST);
  assign status.word_last  = (word_r == WORD_LAST);

  assign digest_word = chain_r[0];
  assign word_number = word_r;

endmodule

`default_nettype wire

/* design/sha256_stream_hasher.sv */
// SHA-256 hasher for a byte stream.
// Input channel: one request per message byte. in_tdata carries the byte,
// in_tuser says whether the byte is present, and in_tlast ends the message
// (a request with in_tlast set and in_tuser clear ends it without a byte).
// Output channel: eight requests per message, digest word 0 first; out_tlast
// marks word 7.
// Each 64th byte starts a block compression in the round unit, one round
// per cycle: 64 rounds and then the chain add, during which in_tready is
// low. After the final request the padding sequencer shifts one pad byte
// per cycle up to byte 56, loads the 64-bit length, and compresses once
// more (twice when the length no longer fits) before the first digest
// word is offered.
// The digest words come from the chain register; while the receiver stalls,
// the current word holds and no new input is accepted until word 7 leaves.
// Reset loads the initial chain value and clears the byte and length counts;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // has_byte
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_number
  output logic             out_tlast   // final_word
);

  sha_cmd_t    cmd;
  sha_status_t status;
  logic [31:0] digest_word;
  logic [2:0]  word_number;

  // Sequencer for byte intake, padding, rounds and digest output.
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_has_byte(in_tuser),
    .in_end     (in_tlast),
    .out_ready  (out_tready),
    .status     (status),
    .cmd        (cmd),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid)
  );

  // Block buffer, round unit and chain value.
  sha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_byte  (in_tdata),
    .status     (status),
    .digest_word(digest_word),
    .word_number(word_number)
  );

  assign out_tdata = {5'b00000, word_number, digest_word};
  assign out_tlast = status.word_last;

`ifndef NO_ASSERTIONS
  // Input and output never both open: one message is in flight at a time.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  // The last-word flag matches word number seven.
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == WORD_LAST)))
    else $error("last-word flag disagrees with word number");

  // Word numbers advance by one on each delivered word.
  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1)))
    else $error("digest word sequence broken");

  // After word seven leaves, the block takes input again.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after digest");
`endif

endmodule

`default_nettype wire
